### design/dss_pkg.sv
// Shared constants and types for the dominator set solver.
package dss_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int BLOCK_W        = 6;
    localparam int MASK_W         = 64;
    localparam int COUNT_W        = 7;
    localparam int CFG_DATA_W     = 7;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLOCK_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENTRY_BLOCK = 1'b1;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 7'd64;
    localparam logic [BLOCK_W-1:0] ENTRY_BLOCK_RST = 6'd0;

    // One loaded row as it travels from the front to the back.
    typedef struct packed {
        logic [BLOCK_W-1:0] row_addr;
        logic [MASK_W-1:0]  pred_mask;
        logic               last_row;
        logic               store;
    } dss_item_t;

endpackage

### design/dss_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/dss_front.sv
// Input front: classifies incoming rows and queues them for the solver.
module dss_front import dss_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BLOCK_W-1:0] s_block_index,
    input  logic [MASK_W-1:0]  s_pred_mask,
    input  logic               s_last_row,
    output logic               q_valid,
    input  logic               q_ready,
    output dss_item_t          q_item
);

    dss_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;
    dss_item_t  item_in;

    // Rows beyond the storage depth are never used, so they are not stored.
    always_comb begin
        item_in.row_addr  = s_block_index;
        item_in.pred_mask = s_pred_mask;
        item_in.last_row  = s_last_row;
        item_in.store     = ({1'b0, s_block_index} < COUNT_W'(MAX_BLOCKS));
    end

    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### design/dss_back.sv
// Solver back end: stores rows, iterates dominator sets and streams them out.
module dss_back import dss_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [COUNT_W-1:0] block_count,
    input  logic [BLOCK_W-1:0] entry_block,
    input  logic               q_valid,
    output logic               q_ready,
    input  dss_item_t          q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [BLOCK_W-1:0] m_dom_block,
    output logic [MASK_W-1:0]  m_dom_mask,
    output logic               m_last_result
);

    localparam int AW = $clog2(MAX_BLOCKS);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_INIT      = 4'd1;
    localparam logic [3:0] ST_BLK       = 4'd2;
    localparam logic [3:0] ST_LATCH     = 4'd3;
    localparam logic [3:0] ST_SCAN      = 4'd4;
    localparam logic [3:0] ST_WB        = 4'd5;
    localparam logic [3:0] ST_EMIT_RD   = 4'd6;
    localparam logic [3:0] ST_EMIT_CAP  = 4'd7;
    localparam logic [3:0] ST_EMIT_HOLD = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [AW-1:0]     n_last_reg, n_last_next;
    logic [MASK_W-1:0] valid_reg, valid_next;
    logic              has_entry_reg, has_entry_next;
    logic [AW-1:0]     entry_reg, entry_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [AW-1:0]     p_reg, p_next;
    logic [AW-1:0]     e_reg, e_next;
    logic              changed_reg, changed_next;
    logic [MASK_W-1:0] preds_reg, preds_next;
    logic [MASK_W-1:0] acc_reg, acc_next;
    logic [MASK_W-1:0] old_reg, old_next;

    logic              m_valid_reg, m_valid_next;
    logic [BLOCK_W-1:0] m_block_reg, m_block_next;
    logic [MASK_W-1:0] m_mask_reg, m_mask_next;
    logic              m_last_reg, m_last_next;

    logic              pred_we;
    logic [AW-1:0]     pred_raddr;
    logic [MASK_W-1:0] pred_rdata;
    logic              dom_we;
    logic [AW-1:0]     dom_waddr, dom_raddr;
    logic [MASK_W-1:0] dom_wdata, dom_rdata;

    logic [AW-1:0]     n_last_calc;
    logic [MASK_W-1:0] row_new;
    logic              row_changed;
    logic              is_entry;

    dss_ram #(.WIDTH(MASK_W), .DEPTH(MAX_BLOCKS)) u_pred_ram (
        .aclk  (aclk),
        .we    (pred_we),
        .waddr (q_item.row_addr[AW-1:0]),
        .wdata (q_item.pred_mask),
        .raddr (pred_raddr),
        .rdata (pred_rdata)
    );

    dss_ram #(.WIDTH(MASK_W), .DEPTH(MAX_BLOCKS)) u_dom_ram (
        .aclk  (aclk),
        .we    (dom_we),
        .waddr (dom_waddr),
        .wdata (dom_wdata),
        .raddr (dom_raddr),
        .rdata (dom_rdata)
    );

    always_comb begin
        if (block_count == '0) begin
            n_last_calc = '0;
        end else if (block_count > COUNT_W'(MAX_BLOCKS)) begin
            n_last_calc = AW'(MAX_BLOCKS - 1);
        end else begin
            n_last_calc = AW'(block_count - 7'd1);
        end
    end

    assign row_new     = acc_reg | (MASK_W'(1) << i_reg);
    assign row_changed = (row_new != old_reg);
    assign is_entry    = has_entry_reg && (i_reg == entry_reg);

    assign q_ready = (state_reg == ST_IDLE);
    assign pred_we = (state_reg == ST_IDLE) && q_valid && q_item.store;
    assign pred_raddr = i_reg;

    always_comb begin
        case (state_reg)
            ST_BLK:     dom_raddr = i_reg;
            ST_LATCH:   dom_raddr = '0;
            ST_SCAN:    dom_raddr = p_reg + AW'(1);
            ST_EMIT_RD: dom_raddr = e_reg;
            default:    dom_raddr = i_reg;
        endcase
    end

    always_comb begin
        dom_we    = 1'b0;
        dom_waddr = i_reg;
        dom_wdata = row_new;
        if (state_reg == ST_INIT) begin
            dom_we    = 1'b1;
            dom_waddr = e_reg;
            dom_wdata = (has_entry_reg && e_reg == entry_reg) ?
                        (MASK_W'(1) << e_reg) : valid_reg;
        end else if (state_reg == ST_WB) begin
            dom_we = row_changed;
        end
    end

    always_comb begin
        state_next     = state_reg;
        n_last_next    = n_last_reg;
        valid_next     = valid_reg;
        has_entry_next = has_entry_reg;
        entry_next     = entry_reg;
        i_next         = i_reg;
        p_next         = p_reg;
        e_next         = e_reg;
        changed_next   = changed_reg;
        preds_next     = preds_reg;
        acc_next       = acc_reg;
        old_next       = old_reg;
        m_valid_next   = m_valid_reg;
        m_block_next   = m_block_reg;
        m_mask_next    = m_mask_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_item.last_row) begin
                    n_last_next    = n_last_calc;
                    valid_next     = {MASK_W{1'b1}} >> (6'd63 - 6'(n_last_calc));
                    has_entry_next = ({1'b0, entry_block} <= 7'(n_last_calc));
                    entry_next     = entry_block[AW-1:0];
                    e_next         = '0;
                    state_next     = ST_INIT;
                end
            end
            ST_INIT: begin
                if (e_reg == n_last_reg) begin
                    i_next       = '0;
                    changed_next = 1'b0;
                    state_next   = ST_BLK;
                end else begin
                    e_next = e_reg + AW'(1);
                end
            end
            ST_BLK: begin
                if (is_entry) begin
                    if (i_reg == n_last_reg) begin
                        i_next       = '0;
                        changed_next = 1'b0;
                        e_next       = '0;
                        state_next   = changed_reg ? ST_BLK : ST_EMIT_RD;
                    end else begin
                        i_next = i_reg + AW'(1);
                    end
                end else begin
                    state_next = ST_LATCH;
                end
            end
            ST_LATCH: begin
                old_next   = dom_rdata;
                preds_next = pred_rdata & valid_reg;
                acc_next   = ((pred_rdata & valid_reg) != '0) ? valid_reg : '0;
                p_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (preds_reg[p_reg]) begin
                    acc_next = acc_reg & dom_rdata;
                end
                if (p_reg == n_last_reg) begin
                    state_next = ST_WB;
                end else begin
                    p_next = p_reg + AW'(1);
                end
            end
            ST_WB: begin
                if (i_reg == n_last_reg) begin
                    i_next       = '0;
                    changed_next = 1'b0;
                    e_next       = '0;
                    state_next   = (changed_reg || row_changed) ? ST_BLK : ST_EMIT_RD;
                end else begin
                    i_next       = i_reg + AW'(1);
                    changed_next = changed_reg || row_changed;
                    state_next   = ST_BLK;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_CAP;
            end
            ST_EMIT_CAP: begin
                m_valid_next = 1'b1;
                m_block_next = BLOCK_W'(e_reg);
                m_mask_next  = dom_rdata;
                m_last_next  = (e_reg == n_last_reg);
                state_next   = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        e_next     = e_reg + AW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            changed_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            changed_reg <= changed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_last_reg    <= n_last_next;
        valid_reg     <= valid_next;
        has_entry_reg <= has_entry_next;
        entry_reg     <= entry_next;
        i_reg         <= i_next;
        p_reg         <= p_next;
        e_reg         <= e_next;
        preds_reg     <= preds_next;
        acc_reg       <= acc_next;
        old_reg       <= old_next;
        m_block_reg   <= m_block_next;
        m_mask_reg    <= m_mask_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_dom_block   = m_block_reg;
    assign m_dom_mask    = m_mask_reg;
    assign m_last_result = m_last_reg;

endmodule

### design/dominator_set_solver_core.sv
// Top level of the dominator set solver: configuration registers, front and back end.
//
//  Channel  | Direction | Handshake          | Payload
//  s_       | in        | s_valid / s_ready  | s_block_index, s_pred_mask, s_last_row
//  m_       | out       | m_valid / m_ready  | m_dom_block, m_dom_mask, m_last_result
//  cfg_     | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// A row that is not last is queued in the front and written to the row memory
// once the back end is idle. A last row starts a solve: the sets are preset, then
// each sweep visits every block other than the entry block (one dominator memory
// read per predecessor candidate) and passes over the entry block, repeated until
// a sweep changes nothing, and finally the results are streamed out, one per block in use.
// Reset is synchronous and active low; it clears the control state only, and
// the row and dominator memories hold whatever they held.
// A stalled output simply holds the back end; the two-entry queue keeps taking
// rows until it is full, and only then does the input side stall.
module dominator_set_solver_core import dss_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BLOCK_W-1:0]    s_block_index,
    input  logic [MASK_W-1:0]     s_pred_mask,
    input  logic                  s_last_row,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BLOCK_W-1:0]    m_dom_block,
    output logic [MASK_W-1:0]     m_dom_mask,
    output logic                  m_last_result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic [COUNT_W-1:0] block_count_reg;
    logic [BLOCK_W-1:0] entry_block_reg;
    logic               q_valid;
    logic               q_ready;
    dss_item_t          q_item;

    // Configuration is to be written only while the block is idle (a rule for the user;
    // the block does not enforce it), so the solver may read these registers directly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_count_reg <= BLOCK_COUNT_RST;
            entry_block_reg <= ENTRY_BLOCK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IDX_BLOCK_COUNT: block_count_reg <= cfg_wr_data;
                CFG_IDX_ENTRY_BLOCK: entry_block_reg <= cfg_wr_data[BLOCK_W-1:0];
                default: ;
            endcase
        end
    end

    dss_front #(.MAX_BLOCKS(MAX_BLOCKS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_block_index (s_block_index),
        .s_pred_mask   (s_pred_mask),
        .s_last_row    (s_last_row),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    dss_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .block_count   (block_count_reg),
        .entry_block   (entry_block_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dom_block   (m_dom_block),
        .m_dom_mask    (m_dom_mask),
        .m_last_result (m_last_result)
    );

endmodule

### design/dss_checker.sv
// Port-level checker for the dominator set solver, bound to the top level.
module dss_checker import dss_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [BLOCK_W-1:0] m_dom_block,
    input logic [MASK_W-1:0]  m_dom_mask,
    input logic               m_last_result
);

    // A waiting result transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dom_block) && $stable(m_dom_mask)
            && $stable(m_last_result))
    else $error("result changed while stalled");

    // Every block dominates itself.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_dom_mask[m_dom_block])
    else $error("result lacks its own block");

    // No result is offered straight after reset.
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
    else $error("result valid after reset");

    // Results after a non-final one follow with a higher block index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_result ##1 !m_valid ##1 !m_valid ##1 m_valid
            |-> m_dom_block == $past(m_dom_block, 3) + 6'd1)
    else $error("result order broken");

endmodule

bind dominator_set_solver_core dss_checker u_dss_checker (.*);
